// File: hw/rtl/percent_escape_decoder_macros.svh
// Assertion helpers for the percent escape decoder.
`ifndef PERCENT_ESCAPE_DECODER_MACROS_SVH
`define PERCENT_ESCAPE_DECODER_MACROS_SVH

`ifndef SYNTH
`define PCTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCTD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PCTD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCTD_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: hw/rtl/pctd_pkg.sv
package pctd_pkg;

    localparam int PCTD_QUEUE_DEPTH = 2;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CHR_PCT = 8'h25;
    localparam logic [7:0] CHR_0   = 8'h30;
    localparam logic [7:0] CHR_9   = 8'h39;
    localparam logic [7:0] CHR_A   = 8'h41;
    localparam logic [7:0] CHR_F   = 8'h46;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    // Results of one request, replayed in order by the back end.
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            bval;
        logic            done;
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[CHR_0:CHR_9], [CHR_A:CHR_F]};
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[CHR_A:CHR_F]})
            v = c - CHR_A + 8'd10;
        else
            v = c - CHR_0;
        return v[3:0];
    endfunction

endpackage

// File: hw/rtl/percent_escape_decoder.sv
// Percent escape decoder.
// Input queue side: push with operation/char_byte while full is low. operation 0
// carries a character, operation 1 ends the string and flushes a pending escape.
// Result queue side: while empty is low, out_byte, byte_valid, last_of_run and
// string_done show the oldest result; pop takes it.
// Each request yields zero to three results: none for a '%' that opens an
// escape or a first hex digit, one for a plain byte or a decoded escape, one
// to three for a malformed escape, one or two for end of string.
// Each result passes the queue, then the result register, before it is shown.
// Throughput: one request per cycle while each yields at most one result and
// pop is held high; the result side drains one result per cycle, so a
// malformed escape holds the back end longer, absorbed by the request queue.
// When pop is held low the queue fills and full rises; no request is lost.
// Reset clears the escape state, the queue pointers and the result valid flag.
module percent_escape_decoder
    import pctd_pkg::*;
#(
    parameter int QUEUE_DEPTH = PCTD_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       operation,
    input  logic [7:0] char_byte,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_of_run,
    output logic       string_done
);

    logic accept;
    logic cmd_push;
    cmd_t cmd;
    cmd_t q_head;
    logic q_empty;
    logic q_rd;

    assign accept = push && !full;

    pctd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .char_byte (char_byte),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    pctd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_push),
        .wr_data (cmd),
        .full    (full),
        .rd      (q_rd),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    pctd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last_of_run (last_of_run),
        .string_done (string_done)
    );

endmodule

// File: hw/rtl/pctd_front.sv
module pctd_front
    import pctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       operation,
    input  logic [7:0] char_byte,
    output logic       cmd_push,
    output cmd_t       cmd
);

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        cmd        = '0;
        cmd.bval   = 1'b1;
        if (accept)
        begin
            if (operation == OP_END)
            begin
                cmd.done   = 1'b1;
                phase_next = PH_IDLE;
                case (phase_reg)
                    PH_PCT:
                    begin
                        cmd.cnt      = 2'd1;
                        cmd.bytes[0] = CHR_PCT;
                    end
                    PH_HIGH:
                    begin
                        cmd.cnt      = 2'd2;
                        cmd.bytes[0] = CHR_PCT;
                        cmd.bytes[1] = held_reg;
                    end
                    default:
                    begin
                        cmd.cnt  = 2'd1;
                        cmd.bval = 1'b0;
                    end
                endcase
            end
            else
            begin
                case (phase_reg)
                    PH_PCT:
                    begin
                        if (is_hex(char_byte))
                        begin
                            held_next  = char_byte;
                            phase_next = PH_HIGH;
                        end
                        else if (char_byte == CHR_PCT)
                        begin
                            cmd.cnt      = 2'd1;
                            cmd.bytes[0] = CHR_PCT;
                        end
                        else
                        begin
                            cmd.cnt      = 2'd2;
                            cmd.bytes[0] = CHR_PCT;
                            cmd.bytes[1] = char_byte;
                            phase_next   = PH_IDLE;
                        end
                    end
                    PH_HIGH:
                    begin
                        if (is_hex(char_byte))
                        begin
                            cmd.cnt      = 2'd1;
                            cmd.bytes[0] = {hex_value(held_reg), hex_value(char_byte)};
                            phase_next   = PH_IDLE;
                        end
                        else if (char_byte == CHR_PCT)
                        begin
                            cmd.cnt      = 2'd2;
                            cmd.bytes[0] = CHR_PCT;
                            cmd.bytes[1] = held_reg;
                            phase_next   = PH_PCT;
                        end
                        else
                        begin
                            cmd.cnt      = 2'd3;
                            cmd.bytes[0] = CHR_PCT;
                            cmd.bytes[1] = held_reg;
                            cmd.bytes[2] = char_byte;
                            phase_next   = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        if (char_byte == CHR_PCT)
                            phase_next = PH_PCT;
                        else
                        begin
                            cmd.cnt      = 2'd1;
                            cmd.bytes[0] = char_byte;
                            phase_next   = PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    assign cmd_push = accept && (cmd.cnt != 2'd0);

endmodule

// File: hw/rtl/pctd_queue.sv
`include "percent_escape_decoder_macros.svh"

module pctd_queue
    import pctd_pkg::*;
#(
    parameter int DEPTH = PCTD_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd,
    output cmd_t rd_data,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0] level_reg;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (level_reg == LW'(DEPTH));
    assign empty   = (level_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (rd)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (wr && !rd)
                level_reg <= level_reg + 1'b1;
            else if (rd && !wr)
                level_reg <= level_reg - 1'b1;
        end
    end

    `PCTD_NEVER(a_q_overflow, clk, rst_n, wr && full && !rd, "queue write while full")
    `PCTD_NEVER(a_q_underflow, clk, rst_n, rd && empty, "queue read while empty")

endmodule

// File: hw/rtl/pctd_back.sv
`include "percent_escape_decoder_macros.svh"

module pctd_back
    import pctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_rd,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_of_run,
    output logic       string_done
);

    cmd_t       cmd_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       last;
    logic       take;

    assign last        = (idx_reg == cmd_reg.cnt - 2'd1);
    assign take        = valid_reg && pop;
    assign q_rd        = !q_empty && (!valid_reg || (take && last));
    assign empty       = !valid_reg;
    assign out_byte    = cmd_reg.bytes[idx_reg];
    assign byte_valid  = cmd_reg.bval;
    assign last_of_run = last;
    assign string_done = cmd_reg.done && last;

    always_ff @(posedge clk)
    begin
        if (q_rd)
            cmd_reg <= q_head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (q_rd)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            if (last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    `PCTD_NEVER(a_bk_zero_cnt, clk, rst_n, valid_reg && (cmd_reg.cnt == 2'd0), "empty request held")
    `PCTD_ASSERT(a_bk_idx, clk, rst_n, valid_reg |-> (idx_reg < cmd_reg.cnt), "index past count")

endmodule
